// ----- rtl/fsq_pkg.sv -----
// shared types and constants of the single-server queue core
// no dependencies; imported by every module under rtl

package fsq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  localparam int unsigned PagesW   = 10;
  localparam int unsigned SppW     = 8;
  localparam int unsigned SecondW  = 32;
  localparam int unsigned BusyW    = 18;
  localparam int unsigned JobsW    = 32;
  localparam int unsigned LatW     = 48;
  localparam int unsigned WaitCntW = 5;

  localparam logic [SppW-1:0] SppReset = SppW'(1);

  // request kinds carried in the func field
  localparam logic FuncArrive = 1'b0;
  localparam logic FuncTick   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [PagesW-1:0] pages;
  } req_t;

  typedef struct packed {
    logic                service_started;
    logic [PagesW-1:0]   started_pages;
    logic [SecondW-1:0]  wait_seconds;
    logic                dropped;
    logic [WaitCntW-1:0] waiting_count;
    logic [BusyW-1:0]    busy_remaining;
    logic [JobsW-1:0]    jobs_total;
    logic [LatW-1:0]     latency_total;
  } rsp_t;

  // one queued job: page count and the second it arrived in
  typedef struct packed {
    logic [PagesW-1:0]  pages;
    logic [SecondW-1:0] arrival;
  } job_t;

endpackage

// ----- rtl/fsq_job_mem.sv -----
// job store: one write port, one registered read port with write bypass
// depends on fsq_pkg

module fsq_job_mem #(
  parameter int unsigned Depth = fsq_pkg::QueueDepthDefault,
  parameter int unsigned PtrW  = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [PtrW-1:0]    wr_addr_i,
  input  fsq_pkg::job_t      wr_data_i,
  input  logic [PtrW-1:0]    rd_addr_i,
  output fsq_pkg::job_t      rd_data_o
);
  import fsq_pkg::*;

  job_t mem_q [Depth];
  job_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // new head entry written this cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/fsq_engine.sv -----
// queue bookkeeping, server state and totals; one request per fire
// depends on fsq_pkg; reads the prefetched head entry from fsq_job_mem

module fsq_engine #(
  parameter int unsigned Depth = fsq_pkg::QueueDepthDefault,
  parameter int unsigned PtrW  = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  fsq_pkg::req_t            req_i,
  input  logic [fsq_pkg::SppW-1:0] spp_i,
  input  fsq_pkg::job_t            head_entry_i,
  output logic                     wr_en_o,
  output logic [PtrW-1:0]          wr_addr_o,
  output fsq_pkg::job_t            wr_data_o,
  output logic [PtrW-1:0]          rd_addr_o,
  output fsq_pkg::rsp_t            rsp_o
);
  import fsq_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = PtrW + 1;

  logic [PtrW-1:0]    head_q, head_d, head_inc;
  logic [CntW-1:0]    count_q, count_d;
  logic [BusyW-1:0]   busy_q, busy_d, busy_load;
  logic [SecondW-1:0] sec_q, sec_d;
  logic [JobsW-1:0]   jobs_q, jobs_d;
  logic [LatW-1:0]    lat_q, lat_d;

  logic               is_tick, full, accept_job, start;
  logic [SumW-1:0]    tail_sum;
  logic [PtrW-1:0]    tail;
  logic [SecondW-1:0] wait_s;
  logic [LatW:0]      lat_sum;
  logic [BusyW-1:0]   service_s;

  always_comb begin
    is_tick    = (req_i.func == FuncTick);
    full       = (count_q == CntW'(Depth));
    accept_job = !is_tick && !full;
    start      = is_tick && (busy_q == '0) && (count_q != '0);

    // tail position, wrapped at the depth
    tail_sum = SumW'(head_q) + SumW'(count_q);
    if (tail_sum >= SumW'(Depth)) begin
      tail = PtrW'(tail_sum - SumW'(Depth));
    end else begin
      tail = PtrW'(tail_sum);
    end

    if (head_q == PtrW'(Depth - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_q + PtrW'(1);
    end

    service_s = BusyW'(head_entry_i.pages * spp_i);
    wait_s    = sec_q - head_entry_i.arrival;
    lat_sum   = {1'b0, lat_q} + (LatW + 1)'(wait_s);

    head_d  = head_q;
    count_d = count_q;
    busy_d  = busy_q;
    sec_d   = sec_q;
    jobs_d  = jobs_q;
    lat_d   = lat_q;

    if (is_tick) begin
      busy_load = start ? service_s : busy_q;
      busy_d    = (busy_load != '0) ? busy_load - BusyW'(1) : busy_load;
      sec_d     = sec_q + SecondW'(1);
      if (start) begin
        head_d  = head_inc;
        count_d = count_q - CntW'(1);
        lat_d   = lat_sum[LatW] ? '1 : lat_sum[LatW-1:0];
      end
    end else begin
      busy_load = busy_q;
      if (accept_job) begin
        count_d = count_q + CntW'(1);
        if (jobs_q != '1) begin
          jobs_d = jobs_q + JobsW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      busy_q  <= '0;
      sec_q   <= '0;
      jobs_q  <= '0;
      lat_q   <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      sec_q   <= sec_d;
      jobs_q  <= jobs_d;
      lat_q   <= lat_d;
    end
  end

  // prefetch the entry that will be at the head after this cycle
  assign rd_addr_o         = fire_i ? head_d : head_q;
  assign wr_en_o           = fire_i && accept_job;
  assign wr_addr_o         = tail;
  assign wr_data_o.pages   = req_i.pages;
  assign wr_data_o.arrival = sec_q;

  always_comb begin
    rsp_o.service_started = start;
    rsp_o.started_pages   = start ? head_entry_i.pages : '0;
    rsp_o.wait_seconds    = start ? wait_s : '0;
    rsp_o.dropped         = !is_tick && full;
    rsp_o.waiting_count   = WaitCntW'(count_d);
    rsp_o.busy_remaining  = busy_d;
    rsp_o.jobs_total      = jobs_d;
    rsp_o.latency_total   = lat_d;
  end

endmodule

// ----- rtl/fifo_single_server_queue_core.sv -----
// top level of the single-server queue core: request and result registers,
// configuration register; depends on fsq_pkg, fsq_job_mem and fsq_engine
//
// usage
//   request channel: in_valid_i / in_stall_o carry in_req_i (func, pages); a
//   request is taken at a rising edge with in_valid_i high and in_stall_o low.
//   func arrive queues a job stamped with the current second, dropped if full;
//   func tick closes one second and may start the oldest job on an idle server.
//   result channel: out_valid_o / out_stall_i carry out_rsp_o, exactly one
//   result per request, in request order.
//   configuration: cfg_valid_i / cfg_ready_o write seconds per page from
//   cfg_data_i; ready is always high, write only while the core is idle.
// throughput
//   a taken request is held in the request register and its result is written
//   to the result register; one request per cycle is sustained while the result
//   side does not stall, set by the single pass from the request register
//   through the engine to the result register, with the head job prefetched
//   from the job store's registered read port.
// reset
//   queue empty, server idle, clock and totals at zero, seconds per page 1;
//   job store contents are not cleared, only written entries are ever read.
// stall
//   a stalled result holds; the request register then stalls its side, so at
//   most two requests are held inside the core.

module fifo_single_server_queue_core #(
  parameter int unsigned QueueDepth = fsq_pkg::QueueDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  fsq_pkg::req_t            in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output fsq_pkg::rsp_t            out_rsp_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [fsq_pkg::SppW-1:0] cfg_data_i
);
  import fsq_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  // request register
  logic in_valid_q, in_valid_d;
  req_t in_req_q;
  // result register
  logic out_valid_q, out_valid_d;
  rsp_t out_rsp_q;
  // seconds per page
  logic [SppW-1:0] spp_q;

  logic out_free, fire, in_take;

  logic            wr_en;
  logic [PtrW-1:0] wr_addr, rd_addr;
  job_t            wr_data, head_entry;
  rsp_t            rsp;

  // handshake: the result register frees up when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      spp_q       <= SppReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        spp_q <= cfg_data_i;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  fsq_engine #(
    .Depth (QueueDepth),
    .PtrW  (PtrW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_i        (in_req_q),
    .spp_i        (spp_q),
    .head_entry_i (head_entry),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_addr_o    (rd_addr),
    .rsp_o        (rsp)
  );

  fsq_job_mem #(
    .Depth (QueueDepth),
    .PtrW  (PtrW)
  ) u_job_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (head_entry)
  );

endmodule

// ----- test/testbench.sv -----
// self-checking bench for fifo_single_server_queue_core: arrival and tick requests,
// a request-level job queue predictor and a field-by-field result check
// depends on rtl/fsq_pkg.sv and rtl/fifo_single_server_queue_core.sv
`timescale 1ns / 100ps

module testbench;
  import fsq_pkg::*;

  localparam int unsigned QDepth     = QueueDepthDefault;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned PhaseItems = 280;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall_o;
  req_t           in_req = '0;
  logic           out_valid_o;
  logic           out_stall = 1'b0;
  rsp_t           out_rsp_o;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready_o;
  logic [SppW-1:0] cfg_data = '0;

  // requests waiting for the driver, and results owed by the core
  req_t req_pend_q[$];
  rsp_t exp_rsp_q[$];

  // predictor state: waiting jobs oldest first, server and totals
  job_t              sim_jobs[$];
  logic [BusyW-1:0]   sim_busy = '0;
  logic [SecondW-1:0] sim_now = '0;
  logic [JobsW-1:0]   sim_jobs_total = '0;
  logic [LatW-1:0]    sim_latency = '0;
  logic [SppW-1:0]    sim_spp = SppReset;

  int unsigned src_idle_pct = 22;
  int unsigned sink_idle_pct = 50;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;

  fifo_single_server_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // advance the queue model by one request and return the result it owes
  function automatic rsp_t queue_sim_step(req_t r);
    rsp_t             o;
    job_t             j;
    logic [BusyW-1:0] prod;
    logic [LatW-1:0]  headroom;
    o = '0;
    if (r.func == FuncArrive) begin
      // a full queue drops the job and leaves every count alone
      if (sim_jobs.size() >= QDepth) begin
        o.dropped = 1'b1;
      end else begin
        j.pages = r.pages;
        j.arrival = sim_now;
        sim_jobs.push_back(j);
        if (sim_jobs_total != '1) sim_jobs_total++;
      end
    end else begin
      // idle server takes the oldest job before the second closes
      if (sim_busy == '0 && sim_jobs.size() > 0) begin
        j = sim_jobs.pop_front();
        o.service_started = 1'b1;
        o.started_pages = j.pages;
        prod = BusyW'(j.pages) * BusyW'(sim_spp);
        sim_busy = prod;
        o.wait_seconds = sim_now - j.arrival;   // modulo 2^32 on a wrapped clock
        headroom = '1 - sim_latency;
        if (headroom < LatW'(o.wait_seconds)) sim_latency = '1;
        else sim_latency = sim_latency + LatW'(o.wait_seconds);
      end
      if (sim_busy != '0) sim_busy--;
      sim_now++;
    end
    o.waiting_count  = WaitCntW'(sim_jobs.size());
    o.busy_remaining = sim_busy;
    o.jobs_total     = sim_jobs_total;
    o.latency_total  = sim_latency;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
    mismatches++;
  endtask

  // request driver: a slot frees when nothing is offered or the offer was taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req <= '0;
    end else if (!in_valid || !in_stall_o) begin
      if (in_valid) exp_rsp_q.push_back(queue_sim_step(in_req));
      if (req_pend_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_req <= req_pend_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: each taken result against the oldest owed one
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (exp_rsp_q.size() == 0) begin
          report_mismatch("result with no request owed", 64'(out_rsp_o.waiting_count), '0);
        end else begin
          want = exp_rsp_q.pop_front();
          if (out_rsp_o.service_started !== want.service_started)
            report_mismatch("service_started", out_rsp_o.service_started,
                            want.service_started);
          if (out_rsp_o.started_pages !== want.started_pages)
            report_mismatch("started_pages", out_rsp_o.started_pages, want.started_pages);
          if (out_rsp_o.wait_seconds !== want.wait_seconds)
            report_mismatch("wait_seconds", out_rsp_o.wait_seconds, want.wait_seconds);
          if (out_rsp_o.dropped !== want.dropped)
            report_mismatch("dropped", out_rsp_o.dropped, want.dropped);
          if (out_rsp_o.waiting_count !== want.waiting_count)
            report_mismatch("waiting_count", out_rsp_o.waiting_count, want.waiting_count);
          if (out_rsp_o.busy_remaining !== want.busy_remaining)
            report_mismatch("busy_remaining", out_rsp_o.busy_remaining,
                            want.busy_remaining);
          if (out_rsp_o.jobs_total !== want.jobs_total)
            report_mismatch("jobs_total", out_rsp_o.jobs_total, want.jobs_total);
          if (out_rsp_o.latency_total !== want.latency_total)
            report_mismatch("latency_total", out_rsp_o.latency_total, want.latency_total);
        end
      end
      out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // watchdog on cycles where no request, result or register write moves
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("[fifo_single_server_queue_core] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // drained: nothing left to send, nothing owed, then the requested slack
  task automatic wait_drained(int unsigned slack);
    do @(negedge clk_i);
    while (req_pend_q.size() != 0 || in_valid || exp_rsp_q.size() != 0);
    repeat (slack) @(posedge clk_i);
  endtask

  task automatic write_spp(logic [SppW-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sim_spp = v;
  endtask

  task automatic push_req(logic f, logic [PagesW-1:0] p);
    req_t r;
    r.func = f;
    r.pages = p;
    req_pend_q.push_back(r);
  endtask

  // bursts of arrivals followed by runs of ticks, so the queue fills and drains
  task automatic queue_random_phase(int unsigned n_items);
    int unsigned made;
    int unsigned k;
    int unsigned tick_max;
    logic [PagesW-1:0] p;
    made = 0;
    // a slow server needs long tick runs to get through even one job
    tick_max = (sim_spp > 8) ? 200 : 40;
    while (made < n_items) begin
      k = $urandom_range(1, 5);
      repeat (k) begin
        if (sim_spp > 8) p = PagesW'($urandom_range(0, 1));
        else if (sim_spp == 0 && $urandom_range(0, 99) < 20) p = PagesW'($urandom);
        else p = PagesW'($urandom_range(0, 15));
        push_req(FuncArrive, p);
        made++;
      end
      k = $urandom_range(1, tick_max);
      repeat (k) begin
        push_req(FuncTick, PagesW'($urandom));
        made++;
      end
    end
  endtask

  initial begin : stimulus
    logic [SppW-1:0] phase_spp[6];
    int unsigned     ph;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part runs with zero seconds per page so large jobs finish at once
    write_spp('0);
    push_req(FuncTick, 10'h3FF);     // tick on an empty queue, pages ignored
    push_req(FuncArrive, 10'h000);   // zero-page job
    push_req(FuncTick, 10'h000);     // starts it with nothing to serve
    push_req(FuncArrive, 10'h3FF);
    push_req(FuncArrive, 10'h001);
    push_req(FuncArrive, 10'h2AA);
    push_req(FuncArrive, 10'h155);
    for (int i = 0; i < 11; i++) push_req(FuncArrive, PagesW'(1 << (i % PagesW)));
    push_req(FuncArrive, 10'h3FE);   // sixteenth job fills the queue
    push_req(FuncArrive, 10'h123);   // full queue, dropped
    push_req(FuncTick, 10'h155);     // oldest starts, having waited zero seconds
    push_req(FuncTick, 10'h2AA);
    push_req(FuncArrive, 10'h0F0);   // room again
    wait_drained(4);

    phase_spp[0] = 8'd1;
    phase_spp[1] = 8'd255;
    phase_spp[2] = 8'd3;
    phase_spp[3] = 8'd0;
    phase_spp[4] = 8'd2;
    phase_spp[5] = SppW'($urandom_range(1, 8));
    for (ph = 0; ph < 6; ph++) begin
      // idling: receiver-heavy, then sender-heavy, then none
      case (ph / 2)
        0: begin
          src_idle_pct = 22;
          sink_idle_pct = 50;
        end
        1: begin
          src_idle_pct = 50;
          sink_idle_pct = 22;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      write_spp(phase_spp[ph]);
      queue_random_phase(PhaseItems);
      wait_drained(4);
    end

    wait_drained(8);
    if (mismatches == 0) begin
      $display("[fifo_single_server_queue_core] OK");
    end else begin
      $display("[fifo_single_server_queue_core] ERROR");
    end
    $finish;
  end

endmodule
